### hw/rtl/clpd_pkg.sv
// Shared constants for the current-limited PI drive: register map, field widths, divide constants.
package clpd_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_KP_GAIN        = 3'd0;
	localparam cfg_idx_t REG_KI_GAIN        = 3'd1;
	localparam cfg_idx_t REG_INTEGRAL_LIMIT = 3'd2;
	localparam cfg_idx_t REG_CURRENT_LIMIT  = 3'd3;
	localparam cfg_idx_t REG_PWM_LIMIT      = 3'd4;
	localparam cfg_idx_t REG_SLEW_STEP      = 3'd5;

	localparam int GAIN_W  = 10;
	localparam int ILIM_W  = 22;
	localparam int LIM_W   = 15;
	localparam int DRIVE_W = 16;

	// floor(x/25) = (x * DIV25_RECIP) >> DIV25_SHIFT, exact for x < 2**31
	localparam logic [31:0] DIV25_RECIP = 32'd2748779070;
	localparam int          DIV25_SHIFT = 36;

endpackage

### hw/rtl/current_limited_pi_drive_with_slew.sv
// Current-limited PI drive with integral clamp and slew-limited drive level.
//
// Each input word carries a commanded drive and a measured current; each produces one
// result word with the duty magnitude, the drive direction and the clamped PI demand.
// The block is a six-stage pipeline plus an output register and takes one word per clock
// cycle unless in_stall is high. Every stage holds its word independently, so empty
// stages fill up while the output is stalled, and the input stalls only once the whole
// pipeline is full. The integral is updated in the first stage and the drive level in
// the last, each once per word and in input order. Registers are written through the cfg
// port (always ready) by the user, only while idle; the block does not enforce this.
module current_limited_pi_drive_with_slew
	import clpd_pkg::*;
#(
	parameter int PWM_FULL_SCALE = 1023
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DRIVE_W-1:0]    commanded_drive,
	input  logic signed [DRIVE_W-1:0]    measured_current,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [LIM_W-1:0]             duty_magnitude,
	output logic                         drive_direction,
	output logic signed [DRIVE_W-1:0]    pi_demand
);

	localparam logic [ILIM_W-1:0] ILIM_RST = ILIM_W'(PWM_FULL_SCALE * 100);
	localparam logic [LIM_W-1:0]  PWM_RST  = LIM_W'(PWM_FULL_SCALE);
	localparam logic [LIM_W-1:0]  SLEW_RST = LIM_W'(PWM_FULL_SCALE / 25);

	// configuration
	logic [GAIN_W-1:0] kp_q, ki_q;
	logic [ILIM_W-1:0] int_lim_q;
	logic [LIM_W-1:0]  cur_lim_q, pwm_lim_q, slew_q;

	// state
	logic signed [22:0]        integ_q;
	logic signed [DRIVE_W-1:0] level_q;

	// pipeline valids and load enables
	logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;

	// stage payloads
	logic signed [DRIVE_W-1:0] cmd_s1, meas_s1;
	logic signed [17:0]        err_s2;
	logic signed [22:0]        integ_s2;
	logic signed [27:0]        pkp_s3;
	logic signed [32:0]        pki_s3;
	logic [30:0]               x_s4;
	logic                      neg_s4;
	logic [26:0]               quo_s5;
	logic                      neg_s5;
	logic signed [DRIVE_W-1:0] dem_s6;

	// combinational
	logic signed [16:0] cmd_x, cur_lim_x, target;
	logic signed [17:0] err_x;
	logic signed [23:0] isum, int_lim_x, integ_new;
	logic signed [33:0] pi_sum;
	logic [32:0]        pi_mag;
	logic [62:0]        quo_prod;
	logic [LIM_W-1:0]   dem_mag;
	logic signed [17:0] lvl_x, dem_x, lvl_up, lvl_dn;
	logic signed [DRIVE_W-1:0] level_new;

	assign cfg_ready = 1'b1;

	// a stage loads when it is empty or its word moves on
	assign ld7 = !out_valid || !out_stall;
	assign ld6 = !v6_q || ld7;
	assign ld5 = !v5_q || ld6;
	assign ld4 = !v4_q || ld5;
	assign ld3 = !v3_q || ld4;
	assign ld2 = !v2_q || ld3;
	assign ld1 = !v1_q || ld2;
	assign in_stall = !ld1;

	// stage 1: target clamp, error, integral
	always_comb begin
		cmd_x     = 17'(cmd_s1);
		cur_lim_x = {2'b00, cur_lim_q};
		if (cmd_x > cur_lim_x)
			target = cur_lim_x;
		else if (cmd_x < -cur_lim_x)
			target = -cur_lim_x;
		else
			target = cmd_x;
		err_x     = 18'(target) - 18'(meas_s1);
		isum      = 24'(integ_q) + 24'(err_x);
		int_lim_x = {2'b00, int_lim_q};
		if (isum > int_lim_x)
			integ_new = int_lim_x;
		else if (isum < -int_lim_x)
			integ_new = -int_lim_x;
		else
			integ_new = isum;
	end

	// stage 3: PI sum, split into magnitude/4 and sign
	always_comb begin
		pi_sum = 34'(pkp_s3) + 34'(pki_s3);
		pi_mag = pi_sum[33] ? 33'(-pi_sum) : pi_sum[32:0];
	end

	// stage 4: divide by 25 (the /4 was taken as a shift)
	assign quo_prod = 63'(x_s4) * 63'(DIV25_RECIP);

	// stage 5: demand clamp
	assign dem_mag = (quo_s5 > 27'(pwm_lim_q)) ? pwm_lim_q : quo_s5[LIM_W-1:0];

	// stage 6: slew toward demand
	always_comb begin
		lvl_x  = 18'(level_q);
		dem_x  = 18'(dem_s6);
		lvl_up = lvl_x + 18'(slew_q);
		lvl_dn = lvl_x - 18'(slew_q);
		if (dem_x > lvl_up)
			level_new = lvl_up[DRIVE_W-1:0];
		else if (dem_x < lvl_dn)
			level_new = lvl_dn[DRIVE_W-1:0];
		else
			level_new = dem_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q      <= GAIN_W'(80);
			ki_q      <= GAIN_W'(1);
			int_lim_q <= ILIM_RST;
			cur_lim_q <= LIM_W'(32767);
			pwm_lim_q <= PWM_RST;
			slew_q    <= SLEW_RST;
			integ_q   <= '0;
			level_q   <= '0;
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
			v3_q      <= 1'b0;
			v4_q      <= 1'b0;
			v5_q      <= 1'b0;
			v6_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_KP_GAIN:        kp_q      <= cfg_data[GAIN_W-1:0];
					REG_KI_GAIN:        ki_q      <= cfg_data[GAIN_W-1:0];
					REG_INTEGRAL_LIMIT: int_lim_q <= cfg_data[ILIM_W-1:0];
					REG_CURRENT_LIMIT:  cur_lim_q <= cfg_data[LIM_W-1:0];
					REG_PWM_LIMIT:      pwm_lim_q <= cfg_data[LIM_W-1:0];
					REG_SLEW_STEP:      slew_q    <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (v1_q && ld2)
				integ_q <= integ_new[22:0];
			if (v6_q && ld7)
				level_q <= level_new;
			if (ld1) v1_q <= in_valid;
			if (ld2) v2_q <= v1_q;
			if (ld3) v3_q <= v2_q;
			if (ld4) v4_q <= v3_q;
			if (ld5) v5_q <= v4_q;
			if (ld6) v6_q <= v5_q;
			if (ld7) out_valid <= v6_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			cmd_s1  <= commanded_drive;
			meas_s1 <= measured_current;
		end
		if (ld2) begin
			err_s2   <= err_x;
			integ_s2 <= integ_new[22:0];
		end
		if (ld3) begin
			pkp_s3 <= $signed({1'b0, kp_q}) * 28'(err_s2);
			pki_s3 <= 33'($signed({1'b0, ki_q}) * 34'(integ_s2));
		end
		if (ld4) begin
			x_s4   <= pi_mag[32:2];
			neg_s4 <= pi_sum[33];
		end
		if (ld5) begin
			quo_s5 <= quo_prod[DIV25_SHIFT +: 27];
			neg_s5 <= neg_s4;
		end
		if (ld6)
			dem_s6 <= neg_s5 ? -DRIVE_W'(dem_mag) : DRIVE_W'(dem_mag);
		if (ld7) begin
			duty_magnitude  <= level_new[DRIVE_W-1] ? LIM_W'(-level_new) : level_new[LIM_W-1:0];
			drive_direction <= (level_new > 0);
			pi_demand       <= dem_s6;
		end
	end

endmodule
